/* rtl/mandelbrot_escape_8_lanes_macros.svh */
//------------------------------------------------------------------------------
// Assertion macros for the mandelbrot escape block
// Implication checks on the block clock with reset masking.
//------------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_8_LANES_MACROS_SVH
`define MANDELBROT_ESCAPE_8_LANES_MACROS_SVH

// same-cycle implication
`define MBE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mbe_pkg.sv */
//------------------------------------------------------------------------------
// mbe_pkg
// Shared widths, constants, types and saturation helpers.
//------------------------------------------------------------------------------
package mbe_pkg;

    localparam int LANES     = 8;
    localparam int FRAC_BITS = 28;

    localparam int IN_W   = 31;
    localparam int REG_W  = 32;
    localparam int SUM_W  = REG_W + 2;
    localparam int PROD_W = 2 * REG_W;
    localparam int OUT_W  = 8;
    localparam int LIM_W  = 8;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(50);

    localparam logic signed [REG_W-1:0] REG_MAX = {1'b0, {(REG_W-1){1'b1}}};
    localparam logic signed [REG_W-1:0] REG_MIN = {1'b1, {(REG_W-1){1'b0}}};

    localparam logic signed [SUM_W-1:0] BOUND_SUM = SUM_W'(64'sd4 <<< FRAC_BITS);

    typedef struct packed {
        logic start;
        logic run;
    } lane_ctrl_t;

    typedef struct packed {
        logic [OUT_W-1:0] member_bits;
        logic             all_escaped;
    } merge_t;

    function automatic logic signed [REG_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(REG_MAX)) begin
            return REG_MAX;
        end else if (v < SUM_W'(REG_MIN)) begin
            return REG_MIN;
        end
        return REG_W'(v);
    endfunction

    function automatic logic signed [REG_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        if (v > PROD_W'(REG_MAX)) begin
            return REG_MAX;
        end else if (v < PROD_W'(REG_MIN)) begin
            return REG_MIN;
        end
        return REG_W'(v);
    endfunction

endpackage

/* rtl/mandelbrot_escape_8_lanes.sv */
//------------------------------------------------------------------------------
// mandelbrot_escape_8_lanes
// Mandelbrot membership byte for eight points sharing one imaginary part.
//------------------------------------------------------------------------------
// Usage:
//   Input channel s_*: eight real parts and one imaginary part, Q3.28.
//   Result channel m_*: one byte, bit 7-i set when lane i stayed bounded.
//   Config channel cfg_*: iteration_limit, to be written only while idle; the block leaves this unchecked.
// Timing:
//   While running, eight lanes each run one complex round per cycle, three
//   32x32 multipliers per lane. After an item is accepted the lanes run
//   iteration_limit rounds and then test the last round, fewer when all
//   lanes escape early; when the test ends and the output slot is free,
//   m_valid rises and s_ready returns together, so a new item waits for
//   the last one to finish.
// Reset:
//   Synchronous active-low aresetn clears control state and loads the
//   iteration limit with 50.
// Stall:
//   A new item is taken while a finished byte waits on m_ready; if the
//   next byte completes before that, the lanes hold until the slot frees.
//------------------------------------------------------------------------------
`include "mandelbrot_escape_8_lanes_macros.svh"

module mandelbrot_escape_8_lanes (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbe_pkg::LIM_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_real_0,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_real_1,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_real_2,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_real_3,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_real_4,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_real_5,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_real_6,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_real_7,
    input  logic signed [mbe_pkg::IN_W-1:0]   s_imag_part,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mbe_pkg::OUT_W-1:0]         m_member_bits
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [mbe_pkg::LIM_W-1:0]        limit_reg;
    logic [mbe_pkg::LIM_W-1:0]        count_reg, count_next;
    logic signed [mbe_pkg::IN_W-1:0]  imag_reg;
    logic                             m_valid_reg, m_valid_next;
    logic [mbe_pkg::OUT_W-1:0]        m_bits_reg, m_bits_next;

    logic signed [mbe_pkg::IN_W-1:0]  real_arr [8];
    logic [mbe_pkg::LANES-1:0]        esc_now;
    mbe_pkg::lane_ctrl_t              lane_ctrl;
    mbe_pkg::merge_t                  merged;
    logic                             s_fire, finish, out_free;

    assign real_arr[0] = s_real_0;
    assign real_arr[1] = s_real_1;
    assign real_arr[2] = s_real_2;
    assign real_arr[3] = s_real_3;
    assign real_arr[4] = s_real_4;
    assign real_arr[5] = s_real_5;
    assign real_arr[6] = s_real_6;
    assign real_arr[7] = s_real_7;

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign s_fire        = s_valid & s_ready;
    assign m_valid       = m_valid_reg;
    assign m_member_bits = m_bits_reg;
    assign out_free      = ~m_valid_reg | m_ready;

    assign finish = (state_reg == ST_RUN)
                  & ((count_reg == limit_reg) | merged.all_escaped);

    assign lane_ctrl.start = s_fire;
    assign lane_ctrl.run   = (state_reg == ST_RUN) & ~finish;

    for (genvar k = 0; k < mbe_pkg::LANES; k++) begin : g_lane
        mbe_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .real_in (real_arr[k]),
            .imag_in ((state_reg == ST_IDLE) ? s_imag_part : imag_reg),
            .esc_now (esc_now[k])
        );
    end

    mbe_merge u_merge (
        .esc_now (esc_now),
        .result  (merged)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_bits_next  = m_bits_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_RUN;
                    count_next = '0;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_bits_next  = merged.member_bits;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_bits_next  = merged.member_bits;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= mbe_pkg::LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid & cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_bits_reg <= m_bits_next;
        if (s_fire) begin
            imag_reg <= s_imag_part;
        end
    end

    `MBE_ASSERT_NEXT(a_accept_starts_run, s_fire, state_reg == ST_RUN,
        "accepted item did not start iteration")
    `MBE_ASSERT_SAME(a_count_in_range, state_reg == ST_RUN, count_reg <= limit_reg,
        "round count passed the iteration limit")
    `MBE_ASSERT_SAME(a_hold_has_output, state_reg == ST_HOLD, m_valid_reg,
        "holding a result while the output slot is empty")
    `MBE_ASSERT_SAME(a_all_escaped_zero, finish && merged.all_escaped,
        merged.member_bits == '0, "all lanes escaped but byte is not zero")

endmodule

/* rtl/mbe_lane.sv */
//------------------------------------------------------------------------------
// mbe_lane
// One iteration lane: one round of z = z*z + c per cycle while run is high, sticky escape flag.
//------------------------------------------------------------------------------
module mbe_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mbe_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [mbe_pkg::IN_W-1:0]     real_in,
    input  logic signed [mbe_pkg::IN_W-1:0]     imag_in,
    output logic                                esc_now
);

    logic signed [mbe_pkg::IN_W-1:0]   cr_reg;
    logic signed [mbe_pkg::REG_W-1:0]  tr_reg, tr_next;
    logic signed [mbe_pkg::REG_W-1:0]  ti_reg, ti_next;
    logic signed [mbe_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                              esc_reg;

    logic signed [mbe_pkg::SUM_W-1:0]  nzr_sum, nzi_sum, mag;
    logic signed [mbe_pkg::REG_W-1:0]  nzr, nzi, two_xy;
    logic signed [mbe_pkg::PROD_W-1:0] sq_r, sq_i;

    always_comb begin
        nzr_sum   = mbe_pkg::SUM_W'(tr_reg) - mbe_pkg::SUM_W'(ti_reg)
                  + mbe_pkg::SUM_W'(cr_reg);
        nzr       = mbe_pkg::sat_sum(nzr_sum);
        two_xy    = mbe_pkg::sat_prod(prod_reg >>> (mbe_pkg::FRAC_BITS - 1));
        nzi_sum   = mbe_pkg::SUM_W'(two_xy) + mbe_pkg::SUM_W'(imag_in);
        nzi       = mbe_pkg::sat_sum(nzi_sum);
        sq_r      = mbe_pkg::PROD_W'(nzr) * mbe_pkg::PROD_W'(nzr);
        sq_i      = mbe_pkg::PROD_W'(nzi) * mbe_pkg::PROD_W'(nzi);
        prod_next = mbe_pkg::PROD_W'(nzr) * mbe_pkg::PROD_W'(nzi);
        tr_next   = mbe_pkg::sat_prod(sq_r >>> mbe_pkg::FRAC_BITS);
        ti_next   = mbe_pkg::sat_prod(sq_i >>> mbe_pkg::FRAC_BITS);
        mag       = mbe_pkg::SUM_W'(tr_reg) + mbe_pkg::SUM_W'(ti_reg);
        esc_now   = esc_reg | (mag > mbe_pkg::BOUND_SUM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg <= 1'b0;
        end else if (ctrl.start) begin
            esc_reg <= 1'b0;
        end else if (ctrl.run) begin
            esc_reg <= esc_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            cr_reg   <= real_in;
            tr_reg   <= '0;
            ti_reg   <= '0;
            prod_reg <= '0;
        end else if (ctrl.run) begin
            tr_reg   <= tr_next;
            ti_reg   <= ti_next;
            prod_reg <= prod_next;
        end
    end

endmodule

/* rtl/mbe_merge.sv */
//------------------------------------------------------------------------------
// mbe_merge
// Combine lane escape flags into the membership byte, MSB first.
//------------------------------------------------------------------------------
module mbe_merge (
    input  logic [mbe_pkg::LANES-1:0] esc_now,
    output mbe_pkg::merge_t           result
);

    always_comb begin
        result.member_bits = '0;
        for (int k = 0; k < mbe_pkg::LANES; k++) begin
            result.member_bits[mbe_pkg::OUT_W-1-k] = ~esc_now[k];
        end
        result.all_escaped = &esc_now;
    end

endmodule
